>>> design/grid_local_peak_detector_defines.svh
// Assertion macros shared by the grid local peak detector RTL.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef GRID_LOCAL_PEAK_DETECTOR_DEFINES_SVH
`define GRID_LOCAL_PEAK_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLPD_ASSERT_COMB(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/glpd_pkg.sv
// Shared sizes, codes and types for the grid local peak detector.
// No dependencies; used by glpd_line_store and grid_local_peak_detector.
`default_nettype none

package glpd_pkg;

    localparam int MAX_COLS     = 32;
    localparam int MAX_ROWS     = 1024;
    localparam int SAMPLE_WIDTH = 32;

    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COLS_CNT_W  = $clog2(MAX_COLS + 1);
    localparam int ROWS_CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = (ROWS_CNT_W > COLS_CNT_W) ? ROWS_CNT_W : COLS_CNT_W;

    // Three line banks, each MAX_COLS words, addressed as {bank, column}.
    localparam int BANK_W    = 2;
    localparam int RAM_DEPTH = 3 << COL_W;
    localparam int ADDR_W    = BANK_W + COL_W;

    localparam logic [BANK_W-1:0] BANK_0 = 2'd0;
    localparam logic [BANK_W-1:0] BANK_1 = 2'd1;
    localparam logic [BANK_W-1:0] BANK_2 = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 2'd1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // Logical line: the row being received, the one before it, and the one before that.
    typedef enum logic [1:0] {
        ROW_CUR,
        ROW_PREV,
        ROW_OLDER
    } row_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_CTR,
        ST_RD_SIDE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic [COL_W-1:0] wr_col;
        sample_t          wr_data;
        logic             rd_en;
        row_sel_t         rd0_row;
        logic [COL_W-1:0] rd0_col;
        row_sel_t         rd1_row;
        logic [COL_W-1:0] rd1_col;
        logic             rotate;
    } store_req_t;

endpackage

`default_nettype wire

>>> design/grid_local_peak_detector.sv
// Grid local peak detector top level: sequencer, configuration and output register.
// Depends on glpd_pkg, glpd_line_store and grid_local_peak_detector_defines.svh.
//
// Usage. Samples of a grid arrive in raster order on the input channel
// (in_valid, in_ready, sample_value), one word per cell. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets row_count (index 0)
// and col_count (index 1); zero acts as one and larger values saturate to the
// buffer limits. A write to either register restarts the frame, and cfg_ready
// is high only while the sequencer is idle. Each result word on the output
// channel (out_valid, out_ready, cell_row, cell_col, is_peak, frame_last) gives
// the four-neighbour verdict for one cell. A sample of row zero produces
// nothing unless it ends a frame. From row one on, a sample gives the verdict
// for the cell above it; that word passes the read-centre, read-side and
// evaluate steps into the output register, and the next sample is taken only
// once the sequencer is idle again, as each verdict needs two reads of the
// shared line store. The final sample of a frame also walks the last row and
// marks the last word with frame_last. Reset clears the position counters and
// sets both sizes to one. When out_ready is low, the sequencer waits in its
// evaluate step with the pending verdict held, so nothing is lost.
`default_nettype none
`include "grid_local_peak_detector_defines.svh"

module grid_local_peak_detector
    import glpd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sample_t                sample_value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [ROW_W-1:0]            cell_row,
    output logic [COL_W-1:0]            cell_col,
    output logic                        is_peak,
    output logic                        frame_last
);

    state_t                  state_reg;
    state_t                  state_next;
    logic [ROWS_CNT_W-1:0]   row_count_reg;
    logic [COLS_CNT_W-1:0]   col_count_reg;
    logic [ROW_W-1:0]        row_pos_reg;
    logic [COL_W-1:0]        col_pos_reg;
    logic [ROWS_CNT_W-1:0]   eff_rows;
    logic [COLS_CNT_W-1:0]   eff_cols;
    logic [ROW_W-1:0]        eff_rows_m1;
    logic [COL_W-1:0]        eff_cols_m1;

    // Position of the incoming sample after the range clamp.
    logic [ROW_W-1:0]        r_in;
    logic [COL_W-1:0]        c_in;
    logic [ROWS_CNT_W-1:0]   r_inc;
    logic [ROW_W-1:0]        row_pos_next;
    logic [COL_W-1:0]        col_pos_next;
    logic                    row_end_in;
    logic                    last_in;
    logic                    has_work;

    // Per-item context kept while its verdicts are produced.
    sample_t                 key_reg;
    logic [ROW_W-1:0]        r_reg;
    logic [COL_W-1:0]        c_reg;
    logic [COL_W-1:0]        j_reg;
    logic                    op_flush_reg;
    logic                    last_reg;
    logic                    row_end_reg;
    sample_t                 center_reg;
    sample_t                 up_reg;

    logic                    in_acc;
    logic                    cfg_acc;
    logic                    cfg_known;
    logic                    out_load;
    logic                    more;
    store_req_t              store_req;
    sample_t                 rd0_data;
    sample_t                 rd1_data;

    logic [COL_W-1:0]        v_col;
    logic                    up_ok;
    logic                    left_ok;
    logic                    right_ok;
    logic                    peak;

    logic                    out_valid_reg;
    logic [ROW_W-1:0]        cell_row_reg;
    logic [COL_W-1:0]        cell_col_reg;
    logic                    is_peak_reg;
    logic                    frame_last_reg;

    // Effective frame size: zero counts as one, oversized values saturate.
    always_comb
    begin
        if (row_count_reg == '0)
            eff_rows = ROWS_CNT_W'(1);
        else if (row_count_reg > ROWS_CNT_W'(MAX_ROWS))
            eff_rows = ROWS_CNT_W'(MAX_ROWS);
        else
            eff_rows = row_count_reg;

        if (col_count_reg == '0)
            eff_cols = COLS_CNT_W'(1);
        else if (col_count_reg > COLS_CNT_W'(MAX_COLS))
            eff_cols = COLS_CNT_W'(MAX_COLS);
        else
            eff_cols = col_count_reg;
    end

    assign eff_rows_m1 = ROW_W'(eff_rows - ROWS_CNT_W'(1));
    assign eff_cols_m1 = COL_W'(eff_cols - COLS_CNT_W'(1));

    // A position left over from a larger frame size restarts at zero.
    assign r_in = ({1'b0, row_pos_reg} >= eff_rows) ? '0 : row_pos_reg;
    assign c_in = ({1'b0, col_pos_reg} >= eff_cols) ? '0 : col_pos_reg;

    assign row_end_in   = (c_in == eff_cols_m1);
    assign last_in      = row_end_in && (r_in == eff_rows_m1);
    assign has_work     = (r_in != '0) || last_in;
    assign r_inc        = {1'b0, r_in} + ROWS_CNT_W'(1);
    assign row_pos_next = row_end_in ? ((r_inc >= eff_rows) ? '0 : r_inc[ROW_W-1:0]) : r_in;
    assign col_pos_next = row_end_in ? '0 : c_in + COL_W'(1);

    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == REG_ROW_COUNT) || (cfg_index == REG_COL_COUNT);

    // Operands of the verdict in progress. An ordinary verdict looks at the
    // previous row with the older row above it and the new sample below it;
    // the end-of-frame pass looks at the current row with the previous row above.
    assign v_col    = op_flush_reg ? j_reg : c_reg;
    assign up_ok    = op_flush_reg ? (r_reg != '0) : (r_reg > ROW_W'(1));
    assign left_ok  = (v_col != '0);
    assign right_ok = (v_col != eff_cols_m1);

    // In the evaluate step the store returns the left and right neighbours.
    assign peak = !((up_ok && (center_reg < up_reg))
                 || (!op_flush_reg && (center_reg < key_reg))
                 || (left_ok && (center_reg < rd0_data))
                 || (right_ok && (center_reg < rd1_data)));

    assign more = op_flush_reg ? (j_reg != eff_cols_m1) : last_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && has_work)
                    state_next = ST_RD_CTR;
            end
            ST_RD_CTR:  state_next = ST_RD_SIDE;
            ST_RD_SIDE: state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (out_load)
                    state_next = more ? ST_RD_CTR : ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // State outputs: handshakes and line store requests. In the idle step
    // in_ready is high, so a valid input word is an accepted one.
    always_comb
    begin
        in_ready          = 1'b0;
        cfg_ready         = 1'b0;
        out_load          = 1'b0;
        store_req         = '0;
        store_req.wr_col  = c_in;
        store_req.wr_data = sample_value;
        store_req.rd0_row = op_flush_reg ? ROW_CUR : ROW_PREV;
        store_req.rd0_col = v_col;
        store_req.rd1_row = op_flush_reg ? ROW_PREV : ROW_OLDER;
        store_req.rd1_col = v_col;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready         = 1'b1;
                cfg_ready        = 1'b1;
                store_req.wr_en  = in_valid;
                store_req.rotate = in_valid && !has_work && row_end_in;
            end
            ST_RD_CTR:
            begin
                store_req.rd_en = 1'b1;
            end
            ST_RD_SIDE:
            begin
                store_req.rd_en   = 1'b1;
                store_req.rd1_row = store_req.rd0_row;
                store_req.rd0_col = v_col - COL_W'(1);
                store_req.rd1_col = v_col + COL_W'(1);
            end
            ST_EVAL:
            begin
                out_load         = !out_valid_reg || out_ready;
                store_req.rotate = out_load && !more && row_end_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    glpd_line_store u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= ROWS_CNT_W'(1);
            col_count_reg <= COLS_CNT_W'(1);
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            op_flush_reg  <= 1'b0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_acc)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT: row_count_reg <= cfg_data[ROWS_CNT_W-1:0];
                    REG_COL_COUNT: col_count_reg <= cfg_data[COLS_CNT_W-1:0];
                    default:       row_count_reg <= row_count_reg;
                endcase
            end

            // A write to a size register restarts the frame; the line banks keep their data.
            priority if (cfg_acc && cfg_known)
            begin
                row_pos_reg <= '0;
                col_pos_reg <= '0;
            end
            else if (in_acc)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end

            if (in_acc)
            begin
                op_flush_reg <= (r_in == '0);
                j_reg        <= '0;
            end
            else if (out_load)
            begin
                if (!op_flush_reg)
                    op_flush_reg <= 1'b1;
                else
                    j_reg <= j_reg + COL_W'(1);
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Item context and verdict payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            key_reg     <= sample_value;
            r_reg       <= r_in;
            c_reg       <= c_in;
            last_reg    <= last_in;
            row_end_reg <= row_end_in;
        end
        if (state_reg == ST_RD_SIDE)
        begin
            center_reg <= rd0_data;
            up_reg     <= rd1_data;
        end
        if (out_load)
        begin
            cell_row_reg   <= op_flush_reg ? r_reg : r_reg - ROW_W'(1);
            cell_col_reg   <= v_col;
            is_peak_reg    <= peak;
            frame_last_reg <= op_flush_reg && (j_reg == eff_cols_m1);
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_row   = cell_row_reg;
    assign cell_col   = cell_col_reg;
    assign is_peak    = is_peak_reg;
    assign frame_last = frame_last_reg;

    `GLPD_ASSERT_COMB(a_flush_col_range, (state_reg != ST_IDLE) && op_flush_reg,
                      {1'b0, j_reg} < eff_cols, "end-of-frame pass beyond last column")
    `GLPD_ASSERT_COMB(a_flush_restarts, (state_reg == ST_EVAL) && op_flush_reg,
                      (row_pos_reg == '0) && (col_pos_reg == '0),
                      "positions not restarted during end-of-frame pass")
    `GLPD_ASSERT_COMB(a_verdict_row, (state_reg != ST_IDLE) && !op_flush_reg,
                      r_reg != '0, "ordinary verdict issued for the first row")

endmodule

`default_nettype wire

>>> design/glpd_line_store.sv
// Line store: three row banks in one memory with one write and two registered reads.
// Depends on glpd_pkg and grid_local_peak_detector_defines.svh.
`default_nettype none
`include "grid_local_peak_detector_defines.svh"

module glpd_line_store
    import glpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire store_req_t req,
    output sample_t         rd0_data,
    output sample_t         rd1_data
);

    logic [BANK_W-1:0] cur_bank_reg;
    logic [BANK_W-1:0] prev_bank_reg;
    logic [BANK_W-1:0] older_bank_reg;
    logic [BANK_W-1:0] rd0_bank;
    logic [BANK_W-1:0] rd1_bank;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd0_addr;
    logic [ADDR_W-1:0] rd1_addr;
    sample_t           rd0_reg;
    sample_t           rd1_reg;
    sample_t           mem [0:RAM_DEPTH-1];

    always_comb
    begin
        unique case (req.rd0_row)
            ROW_CUR:   rd0_bank = cur_bank_reg;
            ROW_PREV:  rd0_bank = prev_bank_reg;
            ROW_OLDER: rd0_bank = older_bank_reg;
            default:   rd0_bank = cur_bank_reg;
        endcase
        unique case (req.rd1_row)
            ROW_CUR:   rd1_bank = cur_bank_reg;
            ROW_PREV:  rd1_bank = prev_bank_reg;
            ROW_OLDER: rd1_bank = older_bank_reg;
            default:   rd1_bank = cur_bank_reg;
        endcase
    end

    assign wr_addr  = {cur_bank_reg, req.wr_col};
    assign rd0_addr = {rd0_bank, req.rd0_col};
    assign rd1_addr = {rd1_bank, req.rd1_col};

    // At the end of a row the banks change roles instead of copying data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_bank_reg   <= BANK_0;
            prev_bank_reg  <= BANK_1;
            older_bank_reg <= BANK_2;
        end
        else if (req.rotate)
        begin
            cur_bank_reg   <= older_bank_reg;
            prev_bank_reg  <= cur_bank_reg;
            older_bank_reg <= prev_bank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd0_reg <= mem[rd0_addr];
            rd1_reg <= mem[rd1_addr];
        end
    end

    assign rd0_data = rd0_reg;
    assign rd1_data = rd1_reg;

    `GLPD_ASSERT_COMB(a_banks_distinct, 1'b1, (cur_bank_reg != prev_bank_reg) && (cur_bank_reg != older_bank_reg) && (prev_bank_reg != older_bank_reg), "line banks overlap")
    `GLPD_ASSERT_COMB(a_no_rw_overlap, req.wr_en, !req.rd_en, "line store read and write in one cycle")

endmodule

`default_nettype wire

>>> bench/grid_local_peak_detector_test.sv
// Self-checking testbench for grid_local_peak_detector: streams grids of samples, predicts
// every per-cell verdict in a local model and compares each result word as it leaves.
// Depends on glpd_pkg and the grid_local_peak_detector RTL; nothing else.
`default_nettype none

module grid_local_peak_detector_test;
    timeunit 1ns;
    timeprecision 1ps;
    import glpd_pkg::*;

    // The two index codes that the block has no register behind.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};

    localparam int RANDOM_ITEMS     = 12;
    localparam int SETTLE_CYCLES    = 12;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES     = 400000;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {VALUES_FULL, VALUES_NARROW, VALUES_EXTREME} value_style_t;

    typedef struct packed {
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic             is_peak;
        logic             frame_last;
    } verdict_t;

    // Every block input has a known value from time zero.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    sample_t                sample_value = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [ROW_W-1:0]       cell_row;
    logic [COL_W-1:0]       cell_col;
    logic                   is_peak;
    logic                   frame_last;

    grid_local_peak_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .is_peak      (is_peak),
        .frame_last   (frame_last)
    );

    // Samples waiting to be offered, and verdicts the block still owes us.
    sample_t  pending_samples[$];
    verdict_t expected_verdicts[$];

    // Local copy of the block's state: three line stores, the raster position and
    // the two size registers exactly as written (before clamping).
    sample_t                 older_line[MAX_COLS];
    sample_t                 prev_line[MAX_COLS];
    sample_t                 cur_line[MAX_COLS];
    int                      row_pos = 0;
    int                      col_pos = 0;
    logic [ROWS_CNT_W-1:0]   row_reg = ROWS_CNT_W'(1);
    logic [COLS_CNT_W-1:0]   col_reg = COLS_CNT_W'(1);

    int  sender_pct = 0;
    int  receiver_pct = 0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  hold_left = 0;
    bit  sample_taken = 1'b0;

    int  failures = 0;
    int  samples_accepted = 0;
    int  verdicts_checked = 0;
    int  frames_done = 0;
    int  phases_run = 0;
    int  cycle_count = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // A size register of zero behaves as one, and anything past the line store
    // or row limit saturates to it.
    function automatic int effective_size(int value, int limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    // Any write to a real register restarts the raster scan; the line stores keep
    // their contents. Writes to the spare indexes change nothing at all.
    function automatic void apply_config(logic [CFG_INDEX_W-1:0] index,
                                         logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_ROW_COUNT: row_reg = data[ROWS_CNT_W-1:0];
            REG_COL_COUNT: col_reg = data[COLS_CNT_W-1:0];
            default:       return;
        endcase
        row_pos = 0;
        col_pos = 0;
    endfunction

    function automatic void note_verdict(int r, int c, logic peak, logic last);
        verdict_t v;
        v.cell_row   = ROW_W'(r);
        v.cell_col   = COL_W'(c);
        v.is_peak    = peak;
        v.frame_last = last;
        expected_verdicts.push_back(v);
    endfunction

    // Works out the verdicts one accepted sample releases. From the second row
    // on, the sample completes the neighbourhood of the cell straight above it.
    // The final sample of a frame also releases the whole last row, which has no
    // row below it. Ties count as peaks: a cell only loses to a strictly larger
    // neighbour.
    function automatic void predict_verdicts(sample_t value);
        int      rows;
        int      cols;
        int      r;
        int      c;
        sample_t centre;
        logic    peak;
        rows = effective_size(int'(row_reg), MAX_ROWS);
        cols = effective_size(int'(col_reg), MAX_COLS);
        r = row_pos;
        c = col_pos;
        if (c >= cols)
            c = 0;
        if (r >= rows)
            r = 0;
        cur_line[c] = value;

        if (r >= 1) begin
            centre = prev_line[c];
            peak = 1'b1;
            if (r >= 2 && older_line[c] > centre)
                peak = 1'b0;
            if (centre < value)
                peak = 1'b0;
            if (c > 0 && centre < prev_line[c - 1])
                peak = 1'b0;
            if (c + 1 < cols && centre < prev_line[c + 1])
                peak = 1'b0;
            note_verdict(r - 1, c, peak, 1'b0);
        end

        if (r == rows - 1 && c == cols - 1) begin
            for (int j = 0; j < cols; j++) begin
                centre = cur_line[j];
                peak = 1'b1;
                if (r >= 1 && prev_line[j] > centre)
                    peak = 1'b0;
                if (j > 0 && centre < cur_line[j - 1])
                    peak = 1'b0;
                if (j + 1 < cols && centre < cur_line[j + 1])
                    peak = 1'b0;
                note_verdict(r, j, peak, j == cols - 1);
            end
        end

        // End of a row: the lines move down one slot.
        if (c == cols - 1) begin
            older_line = prev_line;
            prev_line = cur_line;
            c = 0;
            r++;
            if (r >= rows)
                r = 0;
        end else begin
            c++;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            failures++;
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
        end
    endfunction

    function automatic void check_verdict();
        verdict_t want;
        if (expected_verdicts.size() == 0) begin
            failures++;
            $error("unexpected verdict word: cell_row %0d cell_col %0d", cell_row, cell_col);
            return;
        end
        want = expected_verdicts.pop_front();
        compare_field("cell_row", 32'(want.cell_row), 32'(cell_row));
        compare_field("cell_col", 32'(want.cell_col), 32'(cell_col));
        compare_field("is_peak", 32'(want.is_peak), 32'(is_peak));
        compare_field("frame_last", 32'(want.frame_last), 32'(frame_last));
        verdicts_checked++;
        if (frame_last === 1'b1)
            frames_done++;
    endfunction

    // Monitor: everything is sampled at the rising edge, before the block's own
    // registers move, so the order of processes in the time step does not matter.
    always @(posedge clk) begin
        sample_taken <= in_valid && in_ready;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (in_valid && in_ready) begin
                predict_verdicts(sample_value);
                samples_accepted++;
            end
            if (out_valid && out_ready)
                check_verdict();
        end
    end

    // Sample driver: a new word goes up only once the previous one was taken, and
    // the sender idles at random between words when the current mode says so.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || sample_taken)) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_pct) begin
                in_valid <= 1'b1;
                sample_value <= pending_samples.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver. A long hold, when one is requested, keeps out_ready low for
    // a fixed count of cycles so the block backs up into its input.
    always @(negedge clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d verdicts outstanding",
                     cycle_count, expected_verdicts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin sender_pct = 0;  receiver_pct = 0;  end
            IDLE_SENDER:   begin sender_pct = 51; receiver_pct = 0;  end
            IDLE_RECEIVER: begin sender_pct = 0;  receiver_pct = 51; end
            default:       begin sender_pct = 25; receiver_pct = 25; end
        endcase
    endfunction

    function automatic sample_t next_sample(value_style_t style);
        case (style)
            VALUES_NARROW: return sample_t'(int'($urandom_range(6)) - 3);
            VALUES_EXTREME: begin
                case ($urandom_range(3))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:       return sample_t'($urandom);
        endcase
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, int data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every sample is in and every verdict out, then gives the block
    // a few more cycles, since a first-row sample produces nothing to wait on.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One phase: drain, optionally resize (in random order), then queue samples.
    // Without a resize a spare index is written instead, and the scan must carry on.
    task automatic run_phase(bit write_sizes, int rows_data, int cols_data, int n_items,
                             value_style_t style, bit long_hold);
        wait_idle();
        if (write_sizes) begin
            if ($urandom_range(1)) begin
                write_reg(REG_ROW_COUNT, rows_data);
                write_reg(REG_COL_COUNT, cols_data);
            end else begin
                write_reg(REG_COL_COUNT, cols_data);
                write_reg(REG_ROW_COUNT, rows_data);
            end
        end else begin
            write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
        end
        if (long_hold)
            hold_requests++;
        repeat (n_items)
            pending_samples.push_back(next_sample(style));
        phases_run++;
    endtask

    initial begin
        int           rows_data;
        int           cols_data;
        int           n_items;
        int           frame_cells;
        int           random_items;
        int           phase;
        value_style_t style;

        set_idle(IDLE_NONE);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Power-up sizes are one by one, so each sample is a whole frame and
        // comes back at once as a peak marked last.
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back(SAMPLE_MIN);

        // Zero in both size registers must behave as one.
        wait_idle();
        write_reg(REG_ROW_COUNT, 0);
        write_reg(REG_COL_COUNT, 0);
        pending_samples.push_back('0);

        // A 3x3 grid with ties and both sample extremes. Halfway through, both
        // spare indexes are written; the scan must not restart.
        wait_idle();
        write_reg(REG_ROW_COUNT, 3);
        write_reg(REG_COL_COUNT, 3);
        pending_samples.push_back(5);
        pending_samples.push_back(5);
        pending_samples.push_back(1);
        pending_samples.push_back(5);
        wait_idle();
        write_reg(REG_SPARE_2, -1);
        write_reg(REG_SPARE_3, 0);
        pending_samples.push_back(-7);
        pending_samples.push_back(5);
        pending_samples.push_back(SAMPLE_MIN);
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back(SAMPLE_MAX);

        // A frame of one row: silent until its last sample, then the whole row.
        wait_idle();
        write_reg(REG_ROW_COUNT, 1);
        write_reg(REG_COL_COUNT, 4);
        pending_samples.push_back(1);
        pending_samples.push_back(3);
        pending_samples.push_back(3);
        pending_samples.push_back(2);

        // Rewriting a size in the middle of a frame restarts it from the top.
        wait_idle();
        write_reg(REG_ROW_COUNT, 2);
        write_reg(REG_COL_COUNT, 2);
        pending_samples.push_back(4);
        pending_samples.push_back(8);
        pending_samples.push_back(1);
        wait_idle();
        write_reg(REG_ROW_COUNT, 2);
        pending_samples.push_back(7);
        pending_samples.push_back(7);
        pending_samples.push_back(7);
        pending_samples.push_back(7);

        // Back-pressure: the receiver holds off for a long stretch while samples
        // keep coming from an irregular sender, so the block fills and drops in_ready.
        set_idle(IDLE_SENDER);
        run_phase(1'b1, 4, 5, 10, VALUES_NARROW, 1'b1);

        // Widest line (an oversized column count saturates to the store depth),
        // then a tall oversized row count, left part-way through its frame.
        set_idle(IDLE_BOTH);
        run_phase(1'b1, 2, 45, 2 * MAX_COLS, VALUES_FULL, 1'b0);
        set_idle(IDLE_RECEIVER);
        run_phase(1'b1, 2047, 1, 6, VALUES_NARROW, 1'b0);

        // Random phases, cycling through the idle modes. Most send whole frames
        // with random content; the rest stop mid-frame or keep the old sizes.
        // The item budget may cut the final phase short.
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            set_idle(idle_mode_t'(phase % 4));
            if ($urandom_range(4) == 0) begin
                case ($urandom_range(3))
                    0:       rows_data = 0;
                    1:       rows_data = MAX_ROWS;
                    2:       rows_data = $urandom_range(MAX_ROWS + 1, 2047);
                    default: rows_data = 1;
                endcase
                case ($urandom_range(4))
                    0:       cols_data = 0;
                    1:       cols_data = MAX_COLS;
                    2:       cols_data = $urandom_range(MAX_COLS + 1, 63);
                    3:       cols_data = 64;
                    default: cols_data = 1;
                endcase
            end else begin
                rows_data = $urandom_range(1, 4);
                cols_data = $urandom_range(1, 6);
            end
            frame_cells = effective_size(rows_data, MAX_ROWS)
                        * effective_size(cols_data & 'h3F, MAX_COLS);
            if (frame_cells <= 40 && $urandom_range(3) != 0)
                n_items = frame_cells * ((frame_cells <= 12) ? $urandom_range(1, 3) : 1);
            else
                n_items = $urandom_range(1, (frame_cells < 30) ? frame_cells : 30);
            if (n_items > RANDOM_ITEMS - random_items)
                n_items = RANDOM_ITEMS - random_items;
            style = value_style_t'($urandom_range(2));
            run_phase(phase % 5 != 4, rows_data, cols_data, n_items, style, 1'b0);
            random_items += n_items;
            phase++;
        end

        // Finish with idling off on both sides: drain and wait before reporting.
        set_idle(IDLE_NONE);
        wait_idle();
        repeat (20) @(posedge clk);

        $display("Covered %0d phases: %0d samples in, %0d verdicts checked, %0d frames closed.",
                 phases_run, samples_accepted, verdicts_checked, frames_done);
        $display("Sizes from one up to saturated extremes, spare indexes, restarts, long stall.");
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
